// ===== hdl/swbm_pkg.sv =====
// Shared types, constants and saturation helpers for the stereo width / bass mono block.
// No dependencies; swbm_csr, the main unit and the testbench import this package.
`default_nettype none

package swbm_pkg;

   localparam int COEF_W     = 32;
   localparam int GAIN_W     = 16;
   localparam int GAIN_SHIFT = 15;
   localparam int ACC_W      = 64;
   localparam int WIDE_W     = 66;
   localparam int Y_W        = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int TAP_W      = 3;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd19661;

   // Filter taps, in accumulation order
   localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
   localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
   localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
   localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
   localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;

   typedef enum logic [2:0] {
      REG_WIDTH_GAIN = 3'd0,
      REG_BASS_MONO  = 3'd1,
      REG_COEF_B0    = 3'd2,
      REG_COEF_B1    = 3'd3,
      REG_COEF_B2    = 3'd4,
      REG_COEF_A1    = 3'd5,
      REG_COEF_A2    = 3'd6
   } swbm_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAIN,
      ST_SIDE,
      ST_MUL,
      ST_ADD,
      ST_ROUND,
      ST_FILT,
      ST_MIX
   } swbm_state_type;

   typedef struct packed {
      logic [GAIN_W-1:0]        width_gain;
      logic                     bass_mono_enable;
      logic signed [COEF_W-1:0] coef_b0;
      logic signed [COEF_W-1:0] coef_b1;
      logic signed [COEF_W-1:0] coef_b2;
      logic signed [COEF_W-1:0] coef_a1;
      logic signed [COEF_W-1:0] coef_a2;
   } swbm_cfg_type;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = {{(WIDE_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         sat_acc = hi[ACC_W-1:0];
      end else if (v < lo) begin
         sat_acc = lo[ACC_W-1:0];
      end else begin
         sat_acc = v[ACC_W-1:0];
      end
   endfunction

   function automatic logic signed [Y_W-1:0] sat_y(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         sat_y = hi[Y_W-1:0];
      end else if (v < lo) begin
         sat_y = lo[Y_W-1:0];
      end else begin
         sat_y = v[Y_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/swbm_req_if.sv =====
// Input channel: one stereo sample pair per transaction, valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface swbm_req_if #(parameter int SAMPLE_BITS = 24) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/swbm_rsp_if.sv =====
// Result channel: one processed stereo sample pair per transaction.
// Depends on nothing.
`default_nettype none

interface swbm_rsp_if #(parameter int SAMPLE_BITS = 24) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/swbm_csr.sv =====
// APB-style register file: width gain, bass mono enable and the five biquad coefficients.
// Depends on swbm_pkg.
`default_nettype none

module swbm_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [swbm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [swbm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [swbm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output swbm_pkg::swbm_cfg_type               cfg
);
   import swbm_pkg::*;

   localparam swbm_cfg_type CFG_RESET = '{
      width_gain:       GAIN_RESET,
      bass_mono_enable: 1'b0,
      coef_b0:          '0,
      coef_b1:          '0,
      coef_b2:          '0,
      coef_a1:          '0,
      coef_a2:          '0
   };

   swbm_cfg_type cfg_ff;
   swbm_cfg_type cfg_in;
   swbm_reg_type reg_sel;
   logic         wr_en;

   assign reg_sel    = swbm_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_WIDTH_GAIN: cfg_in.width_gain       = csr_pwdata[GAIN_W-1:0];
            REG_BASS_MONO:  cfg_in.bass_mono_enable = csr_pwdata[0];
            REG_COEF_B0:    cfg_in.coef_b0          = signed'(csr_pwdata);
            REG_COEF_B1:    cfg_in.coef_b1          = signed'(csr_pwdata);
            REG_COEF_B2:    cfg_in.coef_b2          = signed'(csr_pwdata);
            REG_COEF_A1:    cfg_in.coef_a1          = signed'(csr_pwdata);
            REG_COEF_A2:    cfg_in.coef_a2          = signed'(csr_pwdata);
            default:        cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_WIDTH_GAIN: csr_prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.width_gain};
         REG_BASS_MONO:  csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.bass_mono_enable};
         REG_COEF_B0:    csr_prdata = cfg_ff.coef_b0;
         REG_COEF_B1:    csr_prdata = cfg_ff.coef_b1;
         REG_COEF_B2:    csr_prdata = cfg_ff.coef_b2;
         REG_COEF_A1:    csr_prdata = cfg_ff.coef_a1;
         REG_COEF_A2:    csr_prdata = cfg_ff.coef_a2;
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/swbm_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on nothing.
`default_nettype none

module swbm_mul #(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  wire logic                     clock,
   input  wire logic signed [A_W-1:0]    mul_a,
   input  wire logic signed [B_W-1:0]    mul_b,
   output logic signed [A_W+B_W-1:0]     prod
);
   logic signed [A_W+B_W-1:0] prod_ff;

   assign prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= (A_W+B_W)'(mul_a) * (A_W+B_W)'(mul_b);
   end

endmodule

`default_nettype wire

// ===== hdl/stereo_width_bass_mono_unit.sv =====
// Stereo width with bass mono: mid/side split, side gain, biquad low-pass removal of bass side.
// The single shared multiplier is used once for the gain and once per biquad tap, and a new
// stereo pair is accepted only in the idle state, once the previous result has been registered.
// Reset (synchronous, active high): registers to their defaults, filter history to zero.
// Depends on swbm_pkg, swbm_req_if, swbm_rsp_if, swbm_csr, swbm_mul.
`default_nettype none

module stereo_width_bass_mono_unit #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 30
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   swbm_req_if.sink                             req,
   swbm_rsp_if.source                           rsp,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [swbm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [swbm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [swbm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import swbm_pkg::*;

   // Widths: side after gain, multiplier operand, product, side after bass removal, final mix
   localparam int SIDE_W = SAMPLE_BITS + 1;
   localparam int OPB_W  = (SIDE_W > COEF_W) ? SIDE_W : COEF_W;
   localparam int PROD_W = COEF_W + OPB_W;
   localparam int DIFF_W = OPB_W + 1;
   localparam int MIX_W  = DIFF_W + 1;

   localparam logic signed [PROD_W-1:0] SIDE_HI =
      {{(PROD_W-SIDE_W+1){1'b0}}, {(SIDE_W-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] SIDE_LO = ~SIDE_HI;
   localparam logic signed [MIX_W-1:0] OUT_HI =
      {{(MIX_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [MIX_W-1:0] OUT_LO = ~OUT_HI;
   localparam logic signed [WIDE_W-1:0] ROUND_BIAS = WIDE_W'(1) <<< (COEF_FRAC_BITS - 1);

   swbm_cfg_type cfg;

   swbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer state
   swbm_state_type state_ff, state_in;
   logic [TAP_W-1:0] tap_ff, tap_in;

   // Sample and working registers (payload, no reset, apart from out_valid_ff)
   logic signed [SAMPLE_BITS-1:0] left_ff, left_in_r;
   logic signed [SAMPLE_BITS-1:0] right_ff, right_in_r;
   logic signed [DIFF_W-1:0]      side_ff, side_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] lout_ff, lout_in;
   logic signed [SAMPLE_BITS-1:0] rout_ff, rout_in;
   logic                          out_valid_ff, out_valid_in;

   // Filter history (reset to zero)
   logic signed [SIDE_W-1:0] side_prev1_ff, side_prev1_in;
   logic signed [SIDE_W-1:0] side_prev2_ff, side_prev2_in;
   logic signed [Y_W-1:0]    lp_prev1_ff, lp_prev1_in;
   logic signed [Y_W-1:0]    lp_prev2_ff, lp_prev2_in;

   // Shared multiplier
   logic signed [COEF_W-1:0] mul_a;
   logic signed [OPB_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod;

   swbm_mul #(.A_W(COEF_W), .B_W(OPB_W)) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // Datapath helpers
   logic                          accept;
   logic                          out_free;
   logic signed [SIDE_W-1:0]      diff;
   logic signed [PROD_W-1:0]      gain_shift;
   logic signed [SIDE_W-1:0]      side_sat;
   logic signed [SIDE_W-1:0]      side_cur;
   logic signed [ACC_W-1:0]       prod_sat;
   logic signed [WIDE_W-1:0]      acc_sum;
   logic signed [Y_W-1:0]         lp_y;
   logic signed [SIDE_W:0]        mid_sum;
   logic signed [MIX_W-1:0]       mid_w;
   logic signed [MIX_W-1:0]       mix_p;
   logic signed [MIX_W-1:0]       mix_m;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !out_valid_ff || rsp.ready;

   assign rsp.valid     = out_valid_ff;
   assign rsp.left_out  = lout_ff;
   assign rsp.right_out = rout_ff;

   assign diff       = SIDE_W'(left_ff) - SIDE_W'(right_ff);
   assign gain_shift = prod >>> GAIN_SHIFT;
   assign side_cur   = side_ff[SIDE_W-1:0];
   assign prod_sat   = sat_acc(WIDE_W'(prod));
   assign lp_y       = sat_y(acc_ff >>> COEF_FRAC_BITS);

   // Clamp the scaled side to one bit more than a sample
   always_comb begin
      if (gain_shift > SIDE_HI) begin
         side_sat = SIDE_HI[SIDE_W-1:0];
      end else if (gain_shift < SIDE_LO) begin
         side_sat = SIDE_LO[SIDE_W-1:0];
      end else begin
         side_sat = gain_shift[SIDE_W-1:0];
      end
   end

   // Feedback taps subtract, feedforward taps add; each step saturates at 64 bits
   always_comb begin
      if (tap_ff >= TAP_A1) begin
         acc_sum = WIDE_W'(acc_ff) - WIDE_W'(prod_sat);
      end else begin
         acc_sum = WIDE_W'(acc_ff) + WIDE_W'(prod_sat);
      end
   end

   // Mid is the floored half sum; mix both ways and clamp to a sample
   assign mid_sum = (SIDE_W+1)'(left_ff) + (SIDE_W+1)'(right_ff);
   assign mid_w   = MIX_W'(mid_sum >>> 1);
   assign mix_p   = mid_w + MIX_W'(side_ff);
   assign mix_m   = mid_w - MIX_W'(side_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_GAIN;
         ST_GAIN:  state_in = ST_SIDE;
         ST_SIDE:  state_in = cfg.bass_mono_enable ? ST_MUL : ST_MIX;
         ST_MUL:   state_in = ST_ADD;
         ST_ADD:   state_in = (tap_ff == TAP_A2) ? ST_ROUND : ST_MUL;
         ST_ROUND: state_in = ST_FILT;
         ST_FILT:  state_in = ST_MIX;
         ST_MIX:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Multiplier operands: gain product first, then one biquad tap per pass
   always_comb begin
      mul_a = signed'({{(COEF_W-GAIN_W){1'b0}}, cfg.width_gain});
      mul_b = OPB_W'(diff);
      if (state_ff == ST_MUL) begin
         case (tap_ff)
            TAP_B0:  begin mul_a = cfg.coef_b0; mul_b = OPB_W'(side_cur);      end
            TAP_B1:  begin mul_a = cfg.coef_b1; mul_b = OPB_W'(side_prev1_ff); end
            TAP_B2:  begin mul_a = cfg.coef_b2; mul_b = OPB_W'(side_prev2_ff); end
            TAP_A1:  begin mul_a = cfg.coef_a1; mul_b = OPB_W'(lp_prev1_ff);   end
            TAP_A2:  begin mul_a = cfg.coef_a2; mul_b = OPB_W'(lp_prev2_ff);   end
            default: begin mul_a = cfg.coef_b0; mul_b = OPB_W'(side_cur);      end
         endcase
      end
   end

   // Register updates per state
   always_comb begin
      tap_in        = tap_ff;
      left_in_r     = left_ff;
      right_in_r    = right_ff;
      side_in       = side_ff;
      acc_in        = acc_ff;
      lout_in       = lout_ff;
      rout_in       = rout_ff;
      out_valid_in  = out_valid_ff;
      side_prev1_in = side_prev1_ff;
      side_prev2_in = side_prev2_ff;
      lp_prev1_in   = lp_prev1_ff;
      lp_prev2_in   = lp_prev2_ff;

      // Drop the result once the sink takes it
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               left_in_r  = req.left_in;
               right_in_r = req.right_in;
            end
         end
         ST_SIDE: begin
            side_in = DIFF_W'(side_sat);
            tap_in  = TAP_B0;
         end
         ST_ADD: begin
            // First tap loads, later taps accumulate
            acc_in = (tap_ff == TAP_B0) ? prod_sat : sat_acc(acc_sum);
            tap_in = tap_ff + TAP_W'(1);
         end
         ST_ROUND: begin
            acc_in = sat_acc(WIDE_W'(acc_ff) + ROUND_BIAS);
         end
         ST_FILT: begin
            // Advance the filter history and remove the low band from side
            side_prev2_in = side_prev1_ff;
            side_prev1_in = side_cur;
            lp_prev2_in   = lp_prev1_ff;
            lp_prev1_in   = lp_y;
            side_in       = DIFF_W'(side_cur) - DIFF_W'(lp_y);
         end
         ST_MIX: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (mix_p > OUT_HI) begin
                  lout_in = OUT_HI[SAMPLE_BITS-1:0];
               end else if (mix_p < OUT_LO) begin
                  lout_in = OUT_LO[SAMPLE_BITS-1:0];
               end else begin
                  lout_in = mix_p[SAMPLE_BITS-1:0];
               end
               if (mix_m > OUT_HI) begin
                  rout_in = OUT_HI[SAMPLE_BITS-1:0];
               end else if (mix_m < OUT_LO) begin
                  rout_in = OUT_LO[SAMPLE_BITS-1:0];
               end else begin
                  rout_in = mix_m[SAMPLE_BITS-1:0];
               end
            end
         end
         default: begin
            tap_in = tap_ff;
         end
      endcase
   end

   // Control state and filter history
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tap_ff        <= TAP_B0;
         out_valid_ff  <= 1'b0;
         side_prev1_ff <= '0;
         side_prev2_ff <= '0;
         lp_prev1_ff   <= '0;
         lp_prev2_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         tap_ff        <= tap_in;
         out_valid_ff  <= out_valid_in;
         side_prev1_ff <= side_prev1_in;
         side_prev2_ff <= side_prev2_in;
         lp_prev1_ff   <= lp_prev1_in;
         lp_prev2_ff   <= lp_prev2_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      left_ff  <= left_in_r;
      right_ff <= right_in_r;
      side_ff  <= side_in;
      acc_ff   <= acc_in;
      lout_ff  <= lout_in;
      rout_ff  <= rout_in;
   end

endmodule

`default_nettype wire

// ===== sim/stereo_width_bass_mono_unit_tb.sv =====
// Self-checking testbench for stereo_width_bass_mono_unit: mid/side width and bass mono filter.
// Depends on swbm_pkg, swbm_req_if, swbm_rsp_if and the block itself; reads and writes no files.
`default_nettype none

module stereo_width_bass_mono_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import swbm_pkg::*;

   localparam int SW         = 24;   // sample width
   localparam int COEF_FRAC  = 30;   // fraction bits of the filter coefficients
   localparam int PHASES     = 12;   // random configuration phases
   localparam int PHASE_LEN  = 127;  // random transactions per phase
   localparam int TAIL_WAIT  = 20;   // cycles waited past the last result
   localparam int MAX_REPORT = 10;

   localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ACC_MIN = -ACC_MAX - 1;

   localparam logic [31:0] BAD_REG_INDEX = 32'd7;   // first index past the register map

   // Sample extremes, as table words and as output values
   localparam logic [31:0]        P_MAX = 32'h007F_FFFF;
   localparam logic [31:0]        P_MIN = 32'hFF80_0000;
   localparam logic signed [SW-1:0] E_MAX = 24'sh7F_FFFF;
   localparam logic signed [SW-1:0] E_MIN = 24'sh80_0000;
   localparam logic signed [SW-1:0] E_NEG1 = -24'sd1;

   typedef struct packed {
      logic signed [SW-1:0] left;
      logic signed [SW-1:0] right;
   } stereo_pair_type;

   // One note per driven transaction: a typed-in output pair overrides the predictor
   typedef struct {
      bit              fixed;
      stereo_pair_type val;
   } drive_note_type;

   typedef enum logic {ROW_PAIR, ROW_WRITE} row_kind_type;

   // ROW_PAIR: a = left, b = right. ROW_WRITE: a = register index, b = write data.
   typedef struct packed {
      row_kind_type         kind;
      logic [31:0]          a;
      logic [31:0]          b;
      logic                 fixed;
      logic signed [SW-1:0] exp_l;
      logic signed [SW-1:0] exp_r;
   } plan_row_type;

   localparam int PLAN_LEN = 44;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // reset settings: gain 19661, bass mono off
      '{ROW_PAIR,  32'h0,  32'h0,  1'b1, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MAX,  P_MAX,  1'b1, E_MAX,  E_MAX},
      '{ROW_PAIR,  P_MIN,  P_MIN,  1'b1, E_MIN,  E_MIN},
      '{ROW_PAIR,  P_MAX,  P_MIN,  1'b1, E_MAX,  E_MIN},
      '{ROW_PAIR,  P_MIN,  P_MAX,  1'b1, E_MIN,  E_MAX},
      '{ROW_PAIR,  32'd1,  -32'sd1, 1'b0, 24'sh0, 24'sh0},
      // zero gain, junk in the upper data bits: only mid survives
      '{ROW_WRITE, 32'(REG_WIDTH_GAIN), 32'hABCD_0000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MAX,  P_MIN,  1'b1, E_NEG1, E_NEG1},
      '{ROW_PAIR,  -32'sd5, 32'd3, 1'b1, E_NEG1, E_NEG1},
      // gain 1.0, then just under 2.0 where side clips to 25 bits
      '{ROW_WRITE, 32'(REG_WIDTH_GAIN), 32'h0000_8000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  32'd4,  -32'sd4, 1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MAX,  P_MIN,  1'b0, 24'sh0, 24'sh0},
      '{ROW_WRITE, 32'(REG_WIDTH_GAIN), 32'h0000_FFFF, 1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MAX,  P_MIN,  1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MIN,  P_MAX,  1'b0, 24'sh0, 24'sh0},
      // write past the register map: ignored, gain stays
      '{ROW_WRITE, BAD_REG_INDEX, 32'h0000_0000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  32'd100, -32'sd100, 1'b0, 24'sh0, 24'sh0},
      // half gain, pass-through filter: bass mono cancels side completely
      '{ROW_WRITE, 32'(REG_WIDTH_GAIN), 32'h0000_4000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_WRITE, 32'(REG_COEF_B0),    32'h4000_0000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_WRITE, 32'(REG_BASS_MONO),  32'hFFFF_FFFF, 1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  32'd1000, -32'sd1000, 1'b0, 24'sh0, 24'sh0},
      // extreme coefficients: the filter runs away, accumulator and y clip
      '{ROW_WRITE, 32'(REG_COEF_B1),    32'h7FFF_FFFF, 1'b0, 24'sh0, 24'sh0},
      '{ROW_WRITE, 32'(REG_COEF_B2),    32'h8000_0000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_WRITE, 32'(REG_COEF_A1),    32'h8000_0000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_WRITE, 32'(REG_COEF_A2),    32'h7FFF_FFFF, 1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MAX,  P_MIN,  1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MIN,  P_MAX,  1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MAX,  P_MIN,  1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MIN,  P_MAX,  1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MAX,  P_MIN,  1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MIN,  P_MAX,  1'b0, 24'sh0, 24'sh0},
      // bass mono off: filter history must hold across these transactions
      '{ROW_WRITE, 32'(REG_BASS_MONO),  32'hFFFF_FFFE, 1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  32'h0,  32'h0,  1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  P_MAX,  32'h0,  1'b0, 24'sh0, 24'sh0},
      '{ROW_WRITE, 32'(REG_BASS_MONO),  32'h0000_0001, 1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  32'h0,  32'h0,  1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  32'd12345, -32'sd54321, 1'b0, 24'sh0, 24'sh0},
      // new coefficients on top of the old history
      '{ROW_WRITE, 32'(REG_COEF_B0),    32'd45191, 1'b0, 24'sh0, 24'sh0},
      '{ROW_WRITE, 32'(REG_COEF_B1),    32'd90382, 1'b0, 24'sh0, 24'sh0},
      '{ROW_WRITE, 32'(REG_COEF_B2),    32'd45191, 1'b0, 24'sh0, 24'sh0},
      '{ROW_WRITE, 32'(REG_COEF_A1),    -32'sd2127600000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_WRITE, 32'(REG_COEF_A2),    32'd1054000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  32'h0,  32'h0,  1'b0, 24'sh0, 24'sh0},
      '{ROW_PAIR,  32'h0,  32'h0,  1'b0, 24'sh0, 24'sh0}
   };

   logic clock;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   swbm_req_if #(.SAMPLE_BITS(SW)) req_bus ();
   swbm_rsp_if #(.SAMPLE_BITS(SW)) rsp_bus ();

   stereo_width_bass_mono_unit #(
      .SAMPLE_BITS    (SW),
      .COEF_FRAC_BITS (COEF_FRAC)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow of the register file and the filter history
   swbm_cfg_type shadow_cfg;
   longint       side_hist1, side_hist2;
   longint       lowpass_hist1, lowpass_hist2;

   stereo_pair_type pending_out_q [$];   // predicted output pairs, oldest first
   drive_note_type  drive_note_q [$];    // one note per transaction still to be accepted

   int unsigned mismatch_count;
   bit          quiet;                // suppress gaps and stalls for this stretch
   int unsigned stall_left;

   // ---------------------------------------------------------------------
   // Clock and run limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Time limit for the whole run; reaching it counts as a failure
   initial begin
      #10_000_000;
      $display("FAIL stereo_width_bass_mono_unit");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor arithmetic
   // ---------------------------------------------------------------------

   // Clamp v to a signed field of the given width
   function automatic longint clamp_signed(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // One step of the filter sum, clipped to the 64-bit limits
   function automatic longint acc_add(longint a, longint b);
      logic signed [65:0] s;
      s = a;
      s = s + b;
      if (s > ACC_MAX) return ACC_MAX;
      if (s < ACC_MIN) return ACC_MIN;
      return s[63:0];
   endfunction

   // Mid/side width with optional bass mono; advances the filter history when it runs
   task automatic width_mix_predict(input logic signed [SW-1:0] left_s,
                                    input logic signed [SW-1:0] right_s,
                                    output stereo_pair_type res);
      longint l, r, mid, side, acc, y;
      l = left_s;
      r = right_s;
      mid  = (l + r) >>> 1;
      side = clamp_signed(((l - r) * longint'(shadow_cfg.width_gain)) >>> GAIN_SHIFT, SW + 1);
      if (shadow_cfg.bass_mono_enable) begin
         acc = longint'($signed(shadow_cfg.coef_b0)) * side;
         acc = acc_add(acc, longint'($signed(shadow_cfg.coef_b1)) * side_hist1);
         acc = acc_add(acc, longint'($signed(shadow_cfg.coef_b2)) * side_hist2);
         acc = acc_add(acc, -(longint'($signed(shadow_cfg.coef_a1)) * lowpass_hist1));
         acc = acc_add(acc, -(longint'($signed(shadow_cfg.coef_a2)) * lowpass_hist2));
         acc = acc_add(acc, longint'(1) <<< (COEF_FRAC - 1));
         y   = clamp_signed(acc >>> COEF_FRAC, 32);
         side_hist2    = side_hist1;
         side_hist1    = side;
         lowpass_hist2 = lowpass_hist1;
         lowpass_hist1 = y;
         side = side - y;
      end
      res.left  = SW'(clamp_signed(mid + side, SW));
      res.right = SW'(clamp_signed(mid - side, SW));
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Pause length: mostly short, now and then a long one
   function automatic int unsigned pause_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SW-1:0] pick_sample();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)  return E_MAX;
      if (pick < 16) return E_MIN;
      if (pick < 30) return SW'($urandom_range(0, 511)) - SW'(256);
      return SW'($urandom);
   endfunction

   // Drive one sample pair and hold it until the block takes it
   task automatic send_pair(input logic [SW-1:0] left_v, input logic [SW-1:0] right_v,
                            input bit fixed, input logic signed [SW-1:0] exp_l,
                            input logic signed [SW-1:0] exp_r);
      int unsigned gap;
      drive_note_type note;
      gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : pause_len();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      note.fixed     = fixed;
      note.val.left  = exp_l;
      note.val.right = exp_r;
      drive_note_q = {drive_note_q, note};
      req_bus.valid    <= 1'b1;
      req_bus.left_in  <= left_v;
      req_bus.right_in <= right_v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_out_q.size() != 0 || drive_note_q.size() != 0) @(posedge clock);
   endtask

   // APB write: setup cycle, then access until pready; mirror it into the shadow
   task automatic csr_write(input logic [31:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index << 2);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         32'(REG_WIDTH_GAIN): shadow_cfg.width_gain       = value[GAIN_W-1:0];
         32'(REG_BASS_MONO):  shadow_cfg.bass_mono_enable = value[0];
         32'(REG_COEF_B0):    shadow_cfg.coef_b0          = value;
         32'(REG_COEF_B1):    shadow_cfg.coef_b1          = value;
         32'(REG_COEF_B2):    shadow_cfg.coef_b2          = value;
         32'(REG_COEF_A1):    shadow_cfg.coef_a1          = value;
         32'(REG_COEF_A2):    shadow_cfg.coef_a2          = value;
         default: ;   // outside the map: the block ignores it
      endcase
   endtask

   // One of four coefficient choices: a stable low-pass, raw random, corner values, or the current set kept
   task automatic load_coefficients();
      logic [31:0] coef [5];
      logic [31:0] corner [5];
      int unsigned flavor;
      int unsigned a2_v;
      corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h4000_0000, 32'hC000_0000};
      flavor = $urandom_range(0, 9);
      if (flavor < 5) begin
         // keep poles inside the unit circle: |a1| < 1 + a2, a2 < 1
         coef[0] = $urandom_range(1000, 2_000_000);
         coef[1] = coef[0] << 1;
         coef[2] = coef[0];
         a2_v    = $urandom_range(640_000_000, 1_073_000_000);
         coef[3] = -(32'd1_073_741_824 + a2_v - $urandom_range(1_000_000, 300_000_000));
         coef[4] = a2_v;
      end else if (flavor < 7) begin
         foreach (coef[k]) coef[k] = $urandom;
      end else if (flavor < 9) begin
         foreach (coef[k]) coef[k] = corner[$urandom_range(0, 4)];
      end else begin
         return;   // keep the current set; history carries over anyway
      end
      csr_write(32'(REG_COEF_B0), coef[0]);
      csr_write(32'(REG_COEF_B1), coef[1]);
      csr_write(32'(REG_COEF_B2), coef[2]);
      csr_write(32'(REG_COEF_A1), coef[3]);
      csr_write(32'(REG_COEF_A2), coef[4]);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random back-pressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 99) < 20) begin
            stall_left <= pause_len();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitors: predict at input acceptance, compare at result acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      stereo_pair_type predicted;
      drive_note_type  note;
      if (!reset && req_bus.valid && req_bus.ready) begin
         width_mix_predict(req_bus.left_in, req_bus.right_in, predicted);
         note = drive_note_q.pop_front();
         pending_out_q = {pending_out_q, (note.fixed ? note.val : predicted)};
      end
   end

   always @(posedge clock) begin
      stereo_pair_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_out_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORT) begin
               $display("%0t: unexpected result L=%0d R=%0d", $time,
                        rsp_bus.left_out, rsp_bus.right_out);
            end
         end else begin
            want = pending_out_q.pop_front();
            if (rsp_bus.left_out !== want.left || rsp_bus.right_out !== want.right) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORT) begin
                  $display("%0t: mismatch left_out exp %0d got %0d, right_out exp %0d got %0d",
                           $time, want.left, rsp_bus.left_out, want.right, rsp_bus.right_out);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [31:0] gain_v;
      int unsigned pick;

      // hold every driven input at a known value from time zero
      reset            <= 1'b1;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.left_in  <= '0;
      req_bus.right_in <= '0;
      quiet            = 1'b0;

      shadow_cfg.width_gain       = GAIN_RESET;
      shadow_cfg.bass_mono_enable = 1'b0;
      shadow_cfg.coef_b0          = '0;
      shadow_cfg.coef_b1          = '0;
      shadow_cfg.coef_b2          = '0;
      shadow_cfg.coef_a1          = '0;
      shadow_cfg.coef_a2          = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; register writes wait for the block to go idle
      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_WRITE) begin
            wait_for_drain();
            csr_write(PLAN[i].a, PLAN[i].b);
         end else begin
            send_pair(PLAN[i].a[SW-1:0], PLAN[i].b[SW-1:0], PLAN[i].fixed,
                      PLAN[i].exp_l, PLAN[i].exp_r);
         end
      end

      // Random phases: new settings while idle, then a run of random sample pairs
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_drain();
         quiet = (phase % 4 == 1);

         pick = $urandom_range(0, 9);
         case (pick)
            0:       gain_v = 32'd0;
            1:       gain_v = 32'd32768;
            2:       gain_v = 32'd65535;
            3:       gain_v = 32'd16384;
            4:       gain_v = $urandom_range(0, 65535);
            default: gain_v = $urandom_range(0, 32768);
         endcase
         // junk in the unused upper bits must not matter
         gain_v[31:GAIN_W] = (32-GAIN_W)'($urandom);
         csr_write(32'(REG_WIDTH_GAIN), gain_v);
         csr_write(32'(REG_BASS_MONO), {16'($urandom_range(0, 65535)), 15'd0,
                                        1'($urandom_range(0, 3) != 0)});
         load_coefficients();

         for (int n = 0; n < PHASE_LEN; n++) begin
            send_pair(pick_sample(), pick_sample(), 1'b0, '0, '0);
         end
      end

      quiet = 1'b0;
      wait_for_drain();
      repeat (TAIL_WAIT) @(posedge clock);

      if (mismatch_count == 0 && pending_out_q.size() == 0) begin
         $display("PASS stereo_width_bass_mono_unit");
      end else begin
         $display("FAIL stereo_width_bass_mono_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== stereo_width_bass_mono_unit.f =====
hdl/swbm_pkg.sv
hdl/swbm_req_if.sv
hdl/swbm_rsp_if.sv
hdl/swbm_csr.sv
hdl/swbm_mul.sv
hdl/stereo_width_bass_mono_unit.sv
sim/stereo_width_bass_mono_unit_tb.sv
